### src/rotary_knob_event_detector_defines.svh
// Assertion macros shared by the knob event detector modules
`ifndef ROTARY_KNOB_EVENT_DETECTOR_DEFINES_SVH
`define ROTARY_KNOB_EVENT_DETECTOR_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define RKED_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define RKED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/rked_pkg.sv
// Types and constants of the rotary knob event detector
package rked_pkg;

    localparam int TIME_WIDTH  = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int KIND_WIDTH  = 3;
    localparam int STEP_WIDTH  = 15;

    // Configuration register indexes
    localparam logic CFG_SHORT_PRESS = 1'b0;
    localparam logic CFG_TURN_DEAD   = 1'b1;

    localparam logic [CFG_WIDTH-1:0] SHORT_PRESS_RESET = 16'd500;
    localparam logic [CFG_WIDTH-1:0] TURN_DEAD_RESET   = 16'd400;

    // Result event codes
    localparam logic [KIND_WIDTH-1:0] EV_PRESSED        = 3'd0;
    localparam logic [KIND_WIDTH-1:0] EV_RELEASED_SHORT = 3'd1;
    localparam logic [KIND_WIDTH-1:0] EV_RELEASED_LONG  = 3'd2;
    localparam logic [KIND_WIDTH-1:0] EV_RELEASED       = 3'd3;
    localparam logic [KIND_WIDTH-1:0] EV_TURNED         = 3'd4;

    // Job codes passed from classifier to emitter
    localparam logic [1:0] JOB_PRESS     = 2'd0;
    localparam logic [1:0] JOB_REL_SHORT = 2'd1;
    localparam logic [1:0] JOB_REL_LONG  = 2'd2;
    localparam logic [1:0] JOB_TURN      = 2'd3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0]                    kind;
        logic signed [COUNT_WIDTH-1:0] delta;
    } job_t;

endpackage

### src/rked_poll_if.sv
// Poll channel: one encoder and button sample per item
interface rked_poll_if
    import rked_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [TIME_WIDTH-1:0]  timestamp;
    logic                   button_level;
    logic [COUNT_WIDTH-1:0] rotary_count;

    modport source (output valid, output timestamp, output button_level,
                    output rotary_count, input ready);
    modport sink   (input valid, input timestamp, input button_level,
                    input rotary_count, output ready);
endinterface

### src/rked_event_if.sv
// Event channel: one detected knob event per item
interface rked_event_if
    import rked_pkg::*;
();
    logic                          valid;
    logic                          ready;
    logic [KIND_WIDTH-1:0]         event_kind;
    logic signed [COUNT_WIDTH-1:0] turn_delta;
    logic signed [STEP_WIDTH-1:0]  step_delta;
    logic                          last_of_run;

    modport source (output valid, output event_kind, output turn_delta,
                    output step_delta, output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input turn_delta,
                    input step_delta, input last_of_run, output ready);
endinterface

### src/rked_front.sv
// Classifier: tracks button and count state and issues one job per event poll
`include "rotary_knob_event_detector_defines.svh"

module rked_front
    import rked_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    rked_poll_if.sink            poll,
    input  logic                 q_full,
    output logic                 push,
    output job_t                 push_job
);

    logic                   button_held_reg;
    logic [TIME_WIDTH-1:0]  last_change_time_reg;
    logic [TIME_WIDTH-1:0]  last_button_time_reg;
    logic [COUNT_WIDTH-1:0] last_count_reg;
    logic [CFG_WIDTH-1:0]   short_press_reg;
    logic [CFG_WIDTH-1:0]   turn_dead_reg;

    logic                   accept;
    logic                   pressed;
    logic                   press_ev;
    logic                   release_ev;
    logic                   turned;
    logic                   turn_ok;
    logic                   is_short;
    logic [TIME_WIDTH-1:0]  since_change;
    logic [TIME_WIDTH-1:0]  since_button;

    assign poll.ready = !q_full;
    assign accept     = poll.valid && poll.ready;

    // Classify the poll against the held state
    assign pressed      = !poll.button_level;
    assign press_ev     = !button_held_reg && pressed;
    assign release_ev   = button_held_reg && !pressed;
    assign turned       = poll.rotary_count != last_count_reg;
    assign since_change = poll.timestamp - last_change_time_reg;
    assign since_button = poll.timestamp - last_button_time_reg;
    assign is_short     = since_change < TIME_WIDTH'(short_press_reg);
    assign turn_ok      = since_button > TIME_WIDTH'(turn_dead_reg);

    // Build the job; on a press or release poll the button event wins and any turn is dropped
    always_comb
    begin
        push_job.delta = '0;
        push_job.kind  = JOB_TURN;
        if (press_ev)
        begin
            push_job.kind = JOB_PRESS;
        end
        else if (release_ev)
        begin
            push_job.kind = is_short ? JOB_REL_SHORT : JOB_REL_LONG;
        end
        else
        begin
            push_job.delta = poll.rotary_count - last_count_reg;
        end
    end

    assign push = accept && (press_ev || release_ev || (turned && turn_ok));

    // Update tracked state on every accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_held_reg      <= 1'b0;
            last_change_time_reg <= '0;
            last_button_time_reg <= '0;
            last_count_reg       <= '0;
        end
        else if (accept)
        begin
            if (press_ev || release_ev)
            begin
                button_held_reg      <= pressed;
                last_button_time_reg <= poll.timestamp;
            end
            if (press_ev || release_ev || turned)
            begin
                last_change_time_reg <= poll.timestamp;
            end
            last_count_reg <= poll.rotary_count;
        end
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_press_reg <= SHORT_PRESS_RESET;
            turn_dead_reg   <= TURN_DEAD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SHORT_PRESS: short_press_reg <= cfg_data;
                CFG_TURN_DEAD:   turn_dead_reg   <= cfg_data;
            endcase
        end
    end

    `RKED_ASSERT_NEXT(a_press_sets_held, clk, rst_n, accept && press_ev, button_held_reg,
        "press item did not set held state")

endmodule

### src/rked_queue.sv
// Short job queue between classifier and emitter
`include "rotary_knob_event_detector_defines.svh"

module rked_queue
    import rked_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic head_valid,
    output job_t head_job,
    input  logic pop
);

    job_t                  slots [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;

    assign full       = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = slots[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Store pushed jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `RKED_ASSERT_SAME(a_no_push_full, clk, rst_n, push, !full, "push into full queue")
    `RKED_ASSERT_SAME(a_no_pop_empty, clk, rst_n, pop, head_valid, "pop from empty queue")

endmodule

### src/rked_back.sv
// Emitter: expands queued jobs into result items through an output register
`include "rotary_knob_event_detector_defines.svh"

module rked_back
    import rked_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  job_t       head_job,
    output logic       pop,
    rked_event_if.source events
);

    logic                          out_valid_reg;
    logic [KIND_WIDTH-1:0]         kind_reg;
    logic signed [COUNT_WIDTH-1:0] delta_reg;
    logic signed [STEP_WIDTH-1:0]  step_reg;
    logic                          last_reg;
    logic                          phase_reg;

    logic                          advance;
    logic                          is_release;
    logic                          take;
    logic [KIND_WIDTH-1:0]         kind_next;
    logic signed [COUNT_WIDTH-1:0] delta_next;
    logic signed [STEP_WIDTH-1:0]  step_next;
    logic                          last_next;
    logic signed [COUNT_WIDTH-1:0] rounded;

    assign advance    = !out_valid_reg || events.ready;
    assign is_release = (head_job.kind == JOB_REL_SHORT) || (head_job.kind == JOB_REL_LONG);
    assign take       = advance && head_valid;
    // A release job stays at the head for its second item
    assign pop        = take && !(is_release && !phase_reg);

    // Halve toward zero: bias negatives by one before the shift
    assign rounded = head_job.delta + COUNT_WIDTH'(head_job.delta[COUNT_WIDTH-1]);

    // Decode the head job into the next result item
    always_comb
    begin
        delta_next = '0;
        step_next  = '0;
        last_next  = 1'b1;
        kind_next  = EV_PRESSED;
        unique case (head_job.kind)
            JOB_PRESS:
            begin
                kind_next = EV_PRESSED;
            end
            JOB_REL_SHORT:
            begin
                kind_next = phase_reg ? EV_RELEASED : EV_RELEASED_SHORT;
                last_next = phase_reg;
            end
            JOB_REL_LONG:
            begin
                kind_next = phase_reg ? EV_RELEASED : EV_RELEASED_LONG;
                last_next = phase_reg;
            end
            JOB_TURN:
            begin
                kind_next  = EV_TURNED;
                delta_next = head_job.delta;
                step_next  = rounded[COUNT_WIDTH-1:1];
            end
        endcase
    end

    // Hold or refill the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= head_valid;
            end
            if (take && is_release)
            begin
                phase_reg <= !phase_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= kind_next;
            delta_reg <= delta_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
        end
    end

    assign events.valid       = out_valid_reg;
    assign events.event_kind  = kind_reg;
    assign events.turn_delta  = delta_reg;
    assign events.step_delta  = step_reg;
    assign events.last_of_run = last_reg;

    `RKED_ASSERT_SAME(a_phase_on_release, clk, rst_n, phase_reg, head_valid && is_release,
        "second release item pending without a release job")
    `RKED_ASSERT_SAME(a_first_release_not_last, clk, rst_n,
        out_valid_reg && (kind_reg == EV_RELEASED_SHORT || kind_reg == EV_RELEASED_LONG),
        !last_reg && phase_reg, "release timing item marked as last")

endmodule

### src/rotary_knob_event_detector.sv
// Rotary knob event detector: a push button with a rotary encoder, polled one sample per item.
// The block takes one poll item per clock cycle while the queue is not full and delivers one
// event item per clock cycle while the sink is ready. An accepted poll that causes an event is
// written into the job queue and then into the event output register. Most polls cause at most
// one event, but a release causes two (the short or long verdict, then RELEASED), and the event
// output register then holds both in turn; the two-entry job queue between the classifier and
// the emitter absorbs this, and polls are held off only while it is full. Configuration writes
// take effect on the next cycle and should be made only while no poll is in flight.
module rotary_knob_event_detector
    import rked_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    rked_poll_if.sink            poll,
    rked_event_if.source         events
);

    logic q_full;
    logic push;
    job_t push_job;
    logic head_valid;
    job_t head_job;
    logic pop;

    rked_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .poll      (poll),
        .q_full    (q_full),
        .push      (push),
        .push_job  (push_job)
    );

    rked_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    rked_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .events     (events)
    );

endmodule
